[hdl/lpbi_pkg.sv]
// ----------------------------------------------------------------------------
// lpbi_pkg
// Shared types, constants and the CORDIC angle table for the Lorentzian
// line profile bin integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpbi_pkg;

	// fixed field width of all Q16.16 words
	localparam int DATA_W     = 32;
	// CORDIC input pre-shift
	localparam int GUARD_BITS = 24;
	// CORDIC x/y width: 58-bit start values plus gain headroom
	localparam int CORD_W     = 62;
	// angle accumulator width, 2^32 equals a half turn
	localparam int ANG_W      = 34;
	// width of the angle difference magnitude
	localparam int DMAG_W     = 34;
	// point-mode numerator |area| * fwhm * INV_PI
	localparam int NUM_W      = 95;
	// quotient bits built by the divider
	localparam int QT_W       = 33;
	// round(2^32 / pi)
	localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;

	// register indexes on the write port
	typedef enum logic [1:0] {
		REG_AREA   = 2'd0,
		REG_CENTER = 2'd1,
		REG_FWHM   = 2'd2
	} reg_idx_t;

	// line definition
	typedef struct packed {
		logic signed [31:0] area;
		logic signed [31:0] center;
		logic signed [31:0] fwhm;
	} cfg_t;

	// per-word fields carried alongside the CORDIC
	typedef struct packed {
		logic        func;  // 1 point mode
		logic        err;   // negative width
		logic        zw;    // zero width
		logic        dlt;   // center inside bin
		logic        an;    // area negative
		logic [31:0] area;
		logic [31:0] am;    // |area|
		logic [30:0] fw;    // fwhm, nonnegative part
		logic [30:0] ua;    // |2D| >> sh
		logic [30:0] fb;    // fwhm >> sh
		logic [1:0]  sh;
	} side_t;

	// per-word fields carried alongside the divider
	typedef struct packed {
		logic        func;
		logic        err;
		logic        neg;   // sign of point result
		logic [31:0] bval;  // finished binned result
	} tail_t;

	// round(atan(2^-i) / pi * 2^32)
	function automatic logic [30:0] atan_hturn(input int i);
		logic [30:0] r;
		case (i)
			0:  r = 31'd1073741824;
			1:  r = 31'd633866811;
			2:  r = 31'd334917815;
			3:  r = 31'd170009512;
			4:  r = 31'd85334662;
			5:  r = 31'd42708931;
			6:  r = 31'd21359677;
			7:  r = 31'd10680490;
			8:  r = 31'd5340327;
			9:  r = 31'd2670173;
			10: r = 31'd1335088;
			11: r = 31'd667544;
			12: r = 31'd333772;
			13: r = 31'd166886;
			14: r = 31'd83443;
			15: r = 31'd41722;
			16: r = 31'd20861;
			17: r = 31'd10430;
			18: r = 31'd5215;
			19: r = 31'd2608;
			20: r = 31'd1304;
			21: r = 31'd652;
			22: r = 31'd326;
			23: r = 31'd163;
			24: r = 31'd81;
			25: r = 31'd41;
			26: r = 31'd20;
			27: r = 31'd10;
			28: r = 31'd5;
			29: r = 31'd3;
			30: r = 31'd1;
			31: r = 31'd1;
			default: r = 31'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/lorentz_profile_bin_integrator.sv]
// ----------------------------------------------------------------------------
// lorentz_profile_bin_integrator
// Lorentzian line profile: bin integral via CORDIC arctangents, or point
// density via a pipelined divider, Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream takes one word per cycle when ready: tdata = {edge_hi, edge_lo},
//   tuser[0] = func (0 bin integral, 1 point density at edge_lo).
//   m_* stream returns one word per input: tdata = value, tuser[0] = error.
//   wr_en/wr_index/wr_data write area (0), center (1), fwhm (2); write them
//   only while no word is in flight.
// Pipeline stages: 1 prep, CORDIC_ITERS rotations, 1 angle difference,
//   3 multiply, 1 overflow check plus 33 divider bit stages, 1 output
//   register. Every word, either mode, walks the full pipeline in order.
// Throughput: one word per cycle while the pipeline is not held, set by the
//   fully pipelined CORDIC and divider (one stage per iteration / quotient bit).
// Stall: a result waiting with m_tready low holds the whole pipeline; a
//   one-word input skid buffer still takes one more word, then s_tready drops.
// Reset: arst_n clears all valid bits and loads area 1.0, center 12.0,
//   fwhm 1638/65536.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lorentz_profile_bin_integrator #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_ITERS = 24
) (
	input  wire         clk,
	input  wire         arst_n,
	// config write port
	input  wire         wr_en,
	input  wire [1:0]   wr_index,
	input  wire [31:0]  wr_data,
	// input stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [63:0]  s_tdata,   // [31:0] edge_lo, [63:32] edge_hi
	input  wire [0:0]   s_tuser,   // [0] func
	// output stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic [0:0]  m_tuser    // [0] error
);

	localparam int DEN_W = 63 + 34 - FRAC_BITS;
	localparam int SHW   = $clog2(DEN_W);
	localparam int KB0   = 30 - FRAC_BITS;
	localparam int NW    = lpbi_pkg::NUM_W;
	localparam int TB    = lpbi_pkg::QT_W;

	logic               en;
	lpbi_pkg::cfg_t     cfg_q;
	logic               skid_vld_q;
	logic [63:0]        skid_data_q;
	logic               skid_func_q;
	logic               p_vld;
	logic [63:0]        p_data;
	logic               p_func;

	logic               pr_vld;
	lpbi_pkg::side_t    pr_sd;
	logic signed [33:0] pr_yh, pr_yl;

	logic               c_vld;
	lpbi_pkg::side_t    c_sd;
	logic [33:0]        c_dmag;
	logic               c_dneg;

	logic               v_s1, v_s2, v_s3;
	lpbi_pkg::side_t    sd_s1, sd_s2;
	logic               dneg_s1;
	logic [63:0]        pl_s1;
	logic [33:0]        ph_s1;
	logic [62:0]        p1_s1;
	logic [61:0]        squ_s1, sqf_s1;
	logic [34:0]        br_s2;
	logic               bneg_s2;
	logic [62:0]        nlo_s2;
	logic [61:0]        nhi_s2;
	logic [62:0]        den_s2;
	logic [NW-1:0]      num_s3;
	logic [DEN_W-1:0]   dnm_s3;
	lpbi_pkg::tail_t    tl_s3;

	logic [66:0]        bsum;
	logic [34:0]        blim, bmag;
	logic [31:0]        bval;
	logic [SHW-1:0]     shamt;
	lpbi_pkg::tail_t    tl;

	logic               d_vld;
	lpbi_pkg::tail_t    d_tl;
	logic               d_ovf;
	logic [TB-1:0]      d_q;
	logic [TB:0]        rsum;
	logic [TB-1:0]      plim, pmag;
	logic [31:0]        pval;

	logic               out_vld_q;
	logic [31:0]        out_val_q;
	logic               out_err_q;

	// pipeline advances unless a result is waiting with m_tready low
	assign en = !out_vld_q || m_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.area   <= 32'sd65536;
			cfg_q.center <= 32'sd786432;
			cfg_q.fwhm   <= 32'sd1638;
		end else if (wr_en) begin
			case (wr_index)
				lpbi_pkg::REG_AREA:   cfg_q.area   <= wr_data;
				lpbi_pkg::REG_CENTER: cfg_q.center <= wr_data;
				lpbi_pkg::REG_FWHM:   cfg_q.fwhm   <= wr_data;
				default: ;
			endcase
		end
	end

	// input skid buffer, one word
	assign s_tready = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (s_tvalid && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && !skid_vld_q) begin
			skid_data_q <= s_tdata;
			skid_func_q <= s_tuser[0];
		end
	end

	assign p_vld  = skid_vld_q || s_tvalid;
	assign p_data = skid_vld_q ? skid_data_q : s_tdata;
	assign p_func = skid_vld_q ? skid_func_q : s_tuser[0];

	lpbi_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (p_vld),
		.func    (p_func),
		.edge_lo (p_data[31:0]),
		.edge_hi (p_data[63:32]),
		.cfg     (cfg_q),
		.out_vld (pr_vld),
		.out_sd  (pr_sd),
		.out_yh  (pr_yh),
		.out_yl  (pr_yl)
	);

	lpbi_cordic #(
		.ITERS (CORDIC_ITERS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (pr_vld),
		.in_sd    (pr_sd),
		.in_yh    (pr_yh),
		.in_yl    (pr_yl),
		.out_vld  (c_vld),
		.out_sd   (c_sd),
		.out_dmag (c_dmag),
		.out_dneg (c_dneg)
	);

	// multiply stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= c_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// multiply stage 1: partial products of both modes
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1   <= c_sd;
			dneg_s1 <= c_dneg;
			pl_s1   <= 64'(c_sd.am) * 64'(c_dmag[31:0]);
			ph_s1   <= 34'(c_sd.am) * 34'(c_dmag[33:32]);
			p1_s1   <= 63'(c_sd.am) * 63'(c_sd.fw);
			squ_s1  <= 62'(c_sd.ua) * 62'(c_sd.ua);
			sqf_s1  <= 62'(c_sd.fb) * 62'(c_sd.fb);
		end
	end

	// binned product rounded to Q16.16
	assign bsum = 67'(pl_s1) + 67'({ph_s1, 32'd0}) + 67'(64'd2147483648);

	// multiply stage 2: rounding, 1/pi scaling, denominator
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2   <= sd_s1;
			br_s2   <= bsum[66:32];
			bneg_s2 <= sd_s1.an ^ dneg_s1;
			nlo_s2  <= 63'(p1_s1[31:0]) * 63'(lpbi_pkg::INV_PI_Q32);
			nhi_s2  <= 62'(p1_s1[62:32]) * 62'(lpbi_pkg::INV_PI_Q32);
			den_s2  <= 63'(squ_s1) + 63'(sqf_s1);
		end
	end

	// binned saturation and delta fallback
	assign blim  = bneg_s2 ? 35'd2147483648 : 35'd2147483647;
	assign bmag  = (br_s2 > blim) ? blim : br_s2;
	assign shamt = SHW'(KB0) + SHW'({sd_s2.sh, 1'b0});

	always_comb begin
		if (sd_s2.zw) begin
			bval = sd_s2.dlt ? sd_s2.area : 32'd0;
		end else if (bneg_s2) begin
			bval = 32'(-bmag[31:0]);
		end else begin
			bval = bmag[31:0];
		end
		tl.func = sd_s2.func;
		tl.err  = sd_s2.err || (sd_s2.func && (den_s2 == 63'd0));
		tl.neg  = sd_s2.an;
		tl.bval = bval;
	end

	// multiply stage 3: full numerator, denominator scaled by 2^(k-1)
	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= NW'(nlo_s2) + NW'({nhi_s2, 32'd0});
			dnm_s3 <= DEN_W'(den_s2) << shamt;
			tl_s3  <= tl;
		end
	end

	lpbi_divider #(
		.DEN_W (DEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (v_s3),
		.in_tl   (tl_s3),
		.in_num  (num_s3),
		.in_den  (dnm_s3),
		.out_vld (d_vld),
		.out_tl  (d_tl),
		.out_ovf (d_ovf),
		.out_q   (d_q)
	);

	// point result: last rounding bit, saturation, sign
	assign rsum = (TB+1)'(d_q) + (TB+1)'(1);
	assign plim = d_tl.neg ? TB'(33'd2147483648) : TB'(33'd2147483647);
	assign pmag = (d_ovf || (rsum[TB:1] > plim)) ? plim : rsum[TB:1];
	assign pval = d_tl.neg ? 32'(-pmag[31:0]) : pmag[31:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_err_q <= d_tl.err;
			if (d_tl.err) begin
				out_val_q <= 32'd0;
			end else if (d_tl.func) begin
				out_val_q <= pval;
			end else begin
				out_val_q <= d_tl.bval;
			end
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = out_val_q;
	assign m_tuser[0] = out_err_q;

	// an error word always carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
		else $error("error word with nonzero value");

	// the skid buffer only fills while the pipeline is held
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> !$past(en))
		else $error("skid buffer filled while pipeline advancing");

endmodule

`default_nettype wire

[hdl/lpbi_prep.sv]
// ----------------------------------------------------------------------------
// lpbi_prep
// First stage: offsets from the center, magnitudes, pre-scaling for the
// point-mode denominator and special-case flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpbi_prep (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   in_vld,
	input  wire                   func,
	input  wire signed [31:0]     edge_lo,
	input  wire signed [31:0]     edge_hi,
	input  lpbi_pkg::cfg_t        cfg,
	output logic                  out_vld,
	output lpbi_pkg::side_t       out_sd,
	output logic signed [33:0]    out_yh,
	output logic signed [33:0]    out_yl
);

	logic signed [32:0] dh, dl;
	logic [32:0]        adl;
	logic [33:0]        u;
	logic [1:0]         sh;
	lpbi_pkg::side_t    sd;

	// offsets from the center, 33 bits exact
	assign dh  = {edge_hi[31], edge_hi} - {cfg.center[31], cfg.center};
	assign dl  = {edge_lo[31], edge_lo} - {cfg.center[31], cfg.center};
	assign adl = dl[32] ? 33'(-dl) : 33'(dl);
	assign u   = {adl, 1'b0};

	// smallest shift that brings |2D| below 2^31
	always_comb begin
		if (u[33:31] == 3'b000) begin
			sh = 2'd0;
		end else if (u[33:32] == 2'b00) begin
			sh = 2'd1;
		end else begin
			sh = 2'd2;
		end
	end

	always_comb begin
		sd.func = func;
		sd.err  = cfg.fwhm[31];
		sd.zw   = (cfg.fwhm == 32'sd0);
		sd.dlt  = (edge_lo <= cfg.center) && (cfg.center < edge_hi);
		sd.an   = cfg.area[31];
		sd.area = cfg.area;
		sd.am   = cfg.area[31] ? 32'(-cfg.area) : 32'(cfg.area);
		sd.fw   = cfg.fwhm[30:0];
		sd.ua   = 31'(u >> sh);
		sd.fb   = cfg.fwhm[30:0] >> sh;
		sd.sh   = sh;
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_sd <= sd;
			out_yh <= {dh, 1'b0};
			out_yl <= {dl, 1'b0};
		end
	end

endmodule

`default_nettype wire

[hdl/lpbi_cordic.sv]
// ----------------------------------------------------------------------------
// lpbi_cordic
// Two vectoring CORDIC pipelines, one per bin edge, one iteration per stage,
// followed by a stage that forms the angle difference.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpbi_cordic #(
	parameter int ITERS = 24
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       en,
	input  wire                       in_vld,
	input  lpbi_pkg::side_t           in_sd,
	input  wire signed [33:0]         in_yh,
	input  wire signed [33:0]         in_yl,
	output logic                      out_vld,
	output lpbi_pkg::side_t           out_sd,
	output logic [lpbi_pkg::DMAG_W-1:0] out_dmag,
	output logic                      out_dneg
);

	localparam int CW = lpbi_pkg::CORD_W;
	localparam int ZW = lpbi_pkg::ANG_W;
	localparam int G  = lpbi_pkg::GUARD_BITS;

	logic signed [CW-1:0] hx_s [0:ITERS];
	logic signed [CW-1:0] hy_s [0:ITERS];
	logic signed [CW-1:0] lx_s [0:ITERS];
	logic signed [CW-1:0] ly_s [0:ITERS];
	logic signed [ZW-1:0] hz_s [0:ITERS];
	logic signed [ZW-1:0] lz_s [0:ITERS];
	lpbi_pkg::side_t      sd_s [0:ITERS];
	logic                 v_s  [0:ITERS];
	logic signed [ZW:0]   dz;

	// start vectors: x = fwhm, y = 2*(edge - center), both pre-shifted
	assign hx_s[0] = {{(CW-31-G){1'b0}}, in_sd.fw, {G{1'b0}}};
	assign lx_s[0] = {{(CW-31-G){1'b0}}, in_sd.fw, {G{1'b0}}};
	assign hy_s[0] = {{(CW-34-G){in_yh[33]}}, in_yh, {G{1'b0}}};
	assign ly_s[0] = {{(CW-34-G){in_yl[33]}}, in_yl, {G{1'b0}}};
	assign hz_s[0] = '0;
	assign lz_s[0] = '0;
	assign sd_s[0] = in_sd;
	assign v_s[0]  = in_vld;

	// one micro-rotation per stage; y = 0 counts as positive
	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ANG = ZW'(lpbi_pkg::atan_hturn(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (hy_s[i][CW-1]) begin
					hx_s[i+1] <= hx_s[i] - (hy_s[i] >>> i);
					hy_s[i+1] <= hy_s[i] + (hx_s[i] >>> i);
					hz_s[i+1] <= hz_s[i] - ANG;
				end else begin
					hx_s[i+1] <= hx_s[i] + (hy_s[i] >>> i);
					hy_s[i+1] <= hy_s[i] - (hx_s[i] >>> i);
					hz_s[i+1] <= hz_s[i] + ANG;
				end
				if (ly_s[i][CW-1]) begin
					lx_s[i+1] <= lx_s[i] - (ly_s[i] >>> i);
					ly_s[i+1] <= ly_s[i] + (lx_s[i] >>> i);
					lz_s[i+1] <= lz_s[i] - ANG;
				end else begin
					lx_s[i+1] <= lx_s[i] + (ly_s[i] >>> i);
					ly_s[i+1] <= ly_s[i] - (lx_s[i] >>> i);
					lz_s[i+1] <= lz_s[i] + ANG;
				end
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	// angle difference, split into sign and magnitude
	assign dz = {hz_s[ITERS][ZW-1], hz_s[ITERS]} - {lz_s[ITERS][ZW-1], lz_s[ITERS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= v_s[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_sd   <= sd_s[ITERS];
			out_dneg <= dz[ZW];
			out_dmag <= dz[ZW] ? lpbi_pkg::DMAG_W'(-dz) : lpbi_pkg::DMAG_W'(dz);
		end
	end

endmodule

`default_nettype wire

[hdl/lpbi_divider.sv]
// ----------------------------------------------------------------------------
// lpbi_divider
// Pipelined restoring divider for the point-mode density: an overflow
// check stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpbi_divider #(
	parameter int DEN_W = 81
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          in_vld,
	input  lpbi_pkg::tail_t              in_tl,
	input  wire [lpbi_pkg::NUM_W-1:0]    in_num,
	input  wire [DEN_W-1:0]              in_den,
	output logic                         out_vld,
	output lpbi_pkg::tail_t              out_tl,
	output logic                         out_ovf,
	output logic [lpbi_pkg::QT_W-1:0]    out_q
);

	localparam int TB   = lpbi_pkg::QT_W;
	localparam int NW   = lpbi_pkg::NUM_W;
	localparam int SW   = DEN_W + TB;
	localparam int CMPW = (SW > NW ? SW : NW) + 1;

	logic                 v_s   [0:TB];
	lpbi_pkg::tail_t      tl_s  [0:TB];
	logic [NW-1:0]        r_s   [0:TB];
	logic [DEN_W-1:0]     d_s   [0:TB];
	logic [TB-1:0]        q_s   [0:TB];
	logic                 ovf_s [0:TB];
	logic                 ovf;

	// quotient would not fit in TB bits
	assign ovf = CMPW'(in_num) >= (CMPW'(in_den) << TB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tl_s[0]  <= in_tl;
			r_s[0]   <= in_num;
			d_s[0]   <= in_den;
			q_s[0]   <= '0;
			ovf_s[0] <= ovf;
		end
	end

	// one trial subtraction per stage, most significant bit first
	for (genvar m = 0; m < TB; m++) begin : g_bit
		localparam int J = TB - 1 - m;
		logic [CMPW-1:0] trial;
		logic [CMPW-1:0] diff;
		logic            ge;

		assign trial = CMPW'(d_s[m]) << J;
		assign ge    = CMPW'(r_s[m]) >= trial;
		assign diff  = CMPW'(r_s[m]) - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[m+1] <= 1'b0;
			end else if (en) begin
				v_s[m+1] <= v_s[m];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tl_s[m+1]  <= tl_s[m];
				r_s[m+1]   <= ge ? diff[NW-1:0] : r_s[m];
				d_s[m+1]   <= d_s[m];
				q_s[m+1]   <= {q_s[m][TB-2:0], ge};
				ovf_s[m+1] <= ovf_s[m];
			end
		end
	end

	assign out_vld = v_s[TB];
	assign out_tl  = tl_s[TB];
	assign out_ovf = ovf_s[TB];
	assign out_q   = q_s[TB];

endmodule

`default_nettype wire
